// File: design/rte_pkg.sv
// Shared types and constants for the relocation table extractor.
// No dependencies; every module of the block imports this package.
package rte_pkg;

  // Offsets are this many bits; a pair at position 2**OFFSET_BITS overflows.
  localparam int OFFSET_BITS = 16;
  localparam int POS_W       = OFFSET_BITS + 1;

  // Configuration port geometry.
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  localparam logic [1:0] REG_MSB_STEP      = 2'd0;
  localparam logic [1:0] REG_RELATIVE_MODE = 2'd1;
  localparam logic [1:0] REG_BYTE_MODE     = 2'd2;

  localparam logic [7:0] MSB_STEP_RESET = 8'd1;

  // Input item kinds.
  localparam logic MODE_PAIR   = 1'b0;
  localparam logic MODE_FINISH = 1'b1;

  // Command queue between front and back.
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

  typedef enum logic [1:0] {
    ERR_NONE = 2'd0,
    ERR_DIFF = 2'd1,
    ERR_BIG  = 2'd2,
    ERR_LONG = 2'd3
  } err_t;

  typedef enum logic [2:0] {
    CMD_ERR,    // one error result
    CMD_TERM2,  // terminator, absolute mode
    CMD_TERM3,  // terminator, relative mode
    CMD_ABS,    // absolute offset, low byte first
    CMD_REL1,   // short distance
    CMD_REL3    // escape 0x00, then 16-bit distance low byte first
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    err_t        err;
    logic [15:0] pos;
    logic [15:0] distance;
  } cmd_t;

  typedef struct packed {
    logic [7:0] msb_step;
    logic       relative_mode;
    logic       byte_mode;
  } cfg_t;

  // Number of result bytes a command expands to.
  function automatic logic [1:0] cmd_results(cmd_kind_t kind);
    logic [1:0] n;
    unique case (kind)
      CMD_ERR, CMD_REL1:   n = 2'd1;
      CMD_TERM2, CMD_ABS:  n = 2'd2;
      CMD_TERM3, CMD_REL3: n = 2'd3;
      default:             n = 2'd1;
    endcase
    return n;
  endfunction

endpackage

// File: design/rte_front.sv
// Front end: accepts input items, tracks position and last relocation,
// and classifies each item into a command. Depends on rte_pkg.
module rte_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  output logic          full,
  input  logic          mode,
  input  logic [7:0]    byte_first,
  input  logic [7:0]    byte_second,
  input  rte_pkg::cfg_t cfg,
  input  logic          fifo_full,
  output logic          cmd_wr,
  output rte_pkg::cmd_t cmd
);
  import rte_pkg::*;

  logic [POS_W-1:0] pos, pos_next;
  logic [15:0]      last_reloc, last_reloc_next;
  logic             halted, halted_next;

  logic             accept;
  logic             emit;
  logic [7:0]       diff;
  logic [15:0]      pos16;
  logic [15:0]      distance;

  assign full     = fifo_full;
  assign accept   = push && !fifo_full;
  assign diff     = byte_second - byte_first;
  assign pos16    = 16'(pos);
  assign distance = pos16 - last_reloc;
  assign cmd_wr   = accept && emit;

  always_comb begin
    pos_next        = pos;
    last_reloc_next = last_reloc;
    halted_next     = halted;
    emit            = 1'b0;
    cmd.kind        = CMD_ERR;
    cmd.err         = ERR_NONE;
    cmd.pos         = pos16;
    cmd.distance    = distance;
    priority if (halted) begin
      // drop everything until reset
    end else if (mode == MODE_FINISH) begin
      emit            = 1'b1;
      cmd.kind        = cfg.relative_mode ? CMD_TERM3 : CMD_TERM2;
      pos_next        = '0;
      last_reloc_next = '0;
    end else if (pos[OFFSET_BITS]) begin
      emit        = 1'b1;
      cmd.err     = ERR_LONG;
      halted_next = 1'b1;
    end else begin
      pos_next = pos + POS_W'(1);
      priority if (diff == 8'h00) begin
        // unrelocated byte: no result
      end else if (diff != cfg.msb_step) begin
        emit        = 1'b1;
        cmd.err     = ERR_DIFF;
        halted_next = 1'b1;
      end else if (!cfg.relative_mode) begin
        emit     = 1'b1;
        cmd.kind = CMD_ABS;
      end else if (distance[15:8] != 8'h00) begin
        emit = 1'b1;
        if (cfg.byte_mode) begin
          cmd.err     = ERR_BIG;
          halted_next = 1'b1;
        end else begin
          cmd.kind        = CMD_REL3;
          last_reloc_next = pos16;
        end
      end else begin
        emit            = 1'b1;
        cmd.kind        = CMD_REL1;
        last_reloc_next = pos16;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos        <= '0;
      last_reloc <= '0;
      halted     <= 1'b0;
    end else if (accept) begin
      pos        <= pos_next;
      last_reloc <= last_reloc_next;
      halted     <= halted_next;
    end
  end

endmodule

// File: design/rte_cmd_fifo.sv
// Short command queue that decouples the front end from the byte emitter.
// Depends on rte_pkg for the command type and depth.
module rte_cmd_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  rte_pkg::cmd_t wr_data,
  input  logic          rd_en,
  output rte_pkg::cmd_t rd_data,
  output logic          full,
  output logic          empty
);
  import rte_pkg::*;

  cmd_t                  mem [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [FIFO_PTR_W:0]   count;
  logic                  do_wr, do_rd;

  assign full    = (count == (FIFO_PTR_W+1)'(FIFO_DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + FIFO_PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + FIFO_PTR_W'(1);
      end
      unique case ({do_wr, do_rd})
        2'b10:   count <= count + (FIFO_PTR_W+1)'(1);
        2'b01:   count <= count - (FIFO_PTR_W+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// File: design/rte_back.sv
// Back end: expands the command at the queue head into result bytes,
// one per cycle while popped, into the output register. Depends on rte_pkg.
module rte_back (
  input  logic          clk,
  input  logic          rst,
  input  rte_pkg::cmd_t head,
  input  logic          head_valid,
  output logic          head_done,
  input  logic          pop,
  output logic          empty,
  output logic [7:0]    out_byte,
  output logic          last_of_run,
  output logic [1:0]    error_code,
  output logic [15:0]   position
);
  import rte_pkg::*;

  logic       out_valid;
  logic [1:0] idx;
  logic       load;
  logic       last;
  logic [7:0] sel_byte;
  err_t       sel_err;

  assign empty     = !out_valid;
  assign load      = head_valid && (!out_valid || pop);
  assign last      = (idx == cmd_results(head.kind) - 2'd1);
  assign head_done = load && last;

  always_comb begin
    sel_byte = 8'h00;
    sel_err  = ERR_NONE;
    unique case (head.kind)
      CMD_ERR:  sel_err = head.err;
      CMD_ABS:  sel_byte = (idx == 2'd0) ? head.pos[7:0] : head.pos[15:8];
      CMD_REL1: sel_byte = head.distance[7:0];
      CMD_REL3: begin
        unique case (idx)
          2'd1:    sel_byte = head.distance[7:0];
          2'd2:    sel_byte = head.distance[15:8];
          default: sel_byte = 8'h00;
        endcase
      end
      default:  sel_byte = 8'h00;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= last ? 2'd0 : idx + 2'd1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Hold the payload while stalled.
  always_ff @(posedge clk) begin
    if (load) begin
      out_byte    <= sel_byte;
      last_of_run <= last;
      error_code  <= sel_err;
      position    <= head.pos;
    end
  end

endmodule

// File: design/relocation_table_extractor.sv
// Relocation table extractor, top level: configuration registers, front end,
// command queue and byte emitter. Depends on rte_pkg and the rte_* modules.
//
// Byte pairs from two builds of one program stream in through a push/full
// port, one pair per clock; a finish item closes the table with its zero
// terminator. A pair whose difference equals msb_step is a relocation and
// yields two bytes (absolute mode) or one or three bytes (relative mode);
// any other nonzero difference, a distance above 255 in byte mode, or a pair
// past 2**16 bytes yields a single error result and halts the block until
// reset (later items are taken and dropped). Input is taken every cycle as
// long as the four-entry command queue has room; results leave through the
// empty/pop port at one byte per cycle while popped, so an item with three
// results holds the output register for all three bytes and the queue
// absorbs the difference. The output register is the only limit on sustained
// rate: one result byte per clock while popped. With the queue and output
// register empty, an accepted item enters the queue and its first result is
// then registered into the output register. Items with no result only
// advance the position. Registers sit at byte addresses 0 (msb_step), 4
// (relative_mode) and 8 (byte_mode); write them only while the block is idle.
module relocation_table_extractor (
  input  logic        clk,
  input  logic        rst,
  // input queue side
  input  logic        push,
  output logic        full,
  input  logic        mode,
  input  logic [7:0]  byte_first,
  input  logic [7:0]  byte_second,
  // result queue side
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte,
  output logic        last_of_run,
  output logic [1:0]  error_code,
  output logic [15:0] position,
  // configuration port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [rte_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [rte_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [rte_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready
);
  import rte_pkg::*;

  cfg_t       cfg;
  logic       cfg_wr;
  logic [1:0] reg_idx;

  logic       cmd_wr;
  cmd_t       cmd_in;
  cmd_t       cmd_head;
  logic       fifo_full;
  logic       fifo_empty;
  logic       head_done;

  // Register file: one transfer per access phase, no wait states.
  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.msb_step      <= MSB_STEP_RESET;
      cfg.relative_mode <= 1'b0;
      cfg.byte_mode     <= 1'b0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_MSB_STEP:      cfg.msb_step      <= pwdata[7:0];
        REG_RELATIVE_MODE: cfg.relative_mode <= pwdata[0];
        REG_BYTE_MODE:     cfg.byte_mode     <= pwdata[0];
        default:           ;  // unmapped address: drop the write
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_MSB_STEP:      prdata = CFG_DATA_W'(cfg.msb_step);
      REG_RELATIVE_MODE: prdata = CFG_DATA_W'(cfg.relative_mode);
      REG_BYTE_MODE:     prdata = CFG_DATA_W'(cfg.byte_mode);
      default:           prdata = '0;
    endcase
  end

  // Classify each accepted item; only items with results enter the queue.
  rte_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .mode        (mode),
    .byte_first  (byte_first),
    .byte_second (byte_second),
    .cfg         (cfg),
    .fifo_full   (fifo_full),
    .cmd_wr      (cmd_wr),
    .cmd         (cmd_in)
  );

  rte_cmd_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (cmd_wr),
    .wr_data (cmd_in),
    .rd_en   (head_done),
    .rd_data (cmd_head),
    .full    (fifo_full),
    .empty   (fifo_empty)
  );

  // Expand the head command byte by byte; advance the queue on its last byte.
  rte_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (cmd_head),
    .head_valid  (!fifo_empty),
    .head_done   (head_done),
    .pop         (pop),
    .empty       (empty),
    .out_byte    (out_byte),
    .last_of_run (last_of_run),
    .error_code  (error_code),
    .position    (position)
  );

endmodule

// File: design/rte_checker.sv
// Port-level checks for the relocation table extractor, bound to the top.
// Depends on rte_pkg for error codes.
module rte_checker (
  input logic        clk,
  input logic        rst,
  input logic        pop,
  input logic        empty,
  input logic [7:0]  out_byte,
  input logic        last_of_run,
  input logic [1:0]  error_code,
  input logic [15:0] position,
  input logic        pready
);
  import rte_pkg::*;

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(out_byte) && $stable(last_of_run)
      && $stable(error_code) && $stable(position))
    else $error("result changed while stalled");

  // An error is a single zero byte that closes its run.
  a_err_shape: assert property (@(posedge clk) disable iff (rst)
    !empty && error_code != ERR_NONE |-> out_byte == 8'h00 && last_of_run)
    else $error("malformed error result");

  // The rest of a run follows at once and carries the same position.
  a_run_cont: assert property (@(posedge clk) disable iff (rst)
    !empty && pop && !last_of_run |=> !empty && position == $past(position)
      && error_code == ERR_NONE)
    else $error("run broken after non-final result");

  a_pready: assert property (@(posedge clk) disable iff (rst) pready)
    else $error("pready dropped");

endmodule

bind relocation_table_extractor rte_checker u_rte_checker (
  .clk         (clk),
  .rst         (rst),
  .pop         (pop),
  .empty       (empty),
  .out_byte    (out_byte),
  .last_of_run (last_of_run),
  .error_code  (error_code),
  .position    (position),
  .pready      (pready)
);

// File: bench/tb.sv
// Self-checking bench for relocation_table_extractor: pushes byte pairs and
// finish items and checks every popped table byte against a local predictor.
// Depends on rte_pkg and the relocation_table_extractor design files.
`timescale 1ns / 1ps

module tb;
  import rte_pkg::*;

  // Stop the run after this many cycles with no transfer on either side.
  localparam int QUIET_LIMIT = 4000;

  // One expected table byte with its side fields.
  typedef struct {
    logic [7:0]  value;
    logic        last;
    err_t        err;
    logic [15:0] pos;
  } table_byte_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic        push = 1'b0;
  logic        full;
  logic        mode = MODE_PAIR;
  logic [7:0]  byte_first = 8'h00;
  logic [7:0]  byte_second = 8'h00;
  logic        empty;
  logic        pop = 1'b0;
  logic [7:0]  out_byte;
  logic        last_of_run;
  logic [1:0]  error_code;
  logic [15:0] position;

  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  // Predictor state: image position, last relocation and the halt flag,
  // plus a shadow of the three registers at their reset values.
  logic [16:0] img_pos = '0;
  logic [15:0] last_reloc_pos = '0;
  logic        extract_halted = 1'b0;
  logic [7:0]  step_cfg = MSB_STEP_RESET;
  logic        rel_cfg = 1'b0;
  logic        bytemode_cfg = 1'b0;

  // Table bytes predicted but not yet popped, oldest first.
  table_byte_t table_bytes_q[$];

  int  mismatches = 0;
  int  quiet_cycles = 0;
  // Random gaps on the push side and random stalls on the pop side.
  bit  send_idle = 1'b1;
  bit  pop_idle = 1'b1;

  relocation_table_extractor dut (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .mode        (mode),
    .byte_first  (byte_first),
    .byte_second (byte_second),
    .empty       (empty),
    .pop         (pop),
    .out_byte    (out_byte),
    .last_of_run (last_of_run),
    .error_code  (error_code),
    .position    (position),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Mostly back to back, sometimes a short pause, rarely a long one.
  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    else if (r < 90) return $urandom_range(1, 3);
    else return $urandom_range(6, 30);
  endfunction

  function automatic void expect_byte(input logic [7:0] value, input logic last,
                                      input err_t err, input logic [15:0] pos);
    table_byte_t b;
    b.value = value;
    b.last  = last;
    b.err   = err;
    b.pos   = pos;
    table_bytes_q.push_back(b);
  endfunction

  // Work out the table bytes one accepted item yields and advance the
  // predictor state. A halted extractor drops every item.
  function automatic void extract_bytes(input logic m, input logic [7:0] b1,
                                        input logic [7:0] b2);
    logic [16:0] at;
    logic [7:0]  diff;
    logic [15:0] distance;
    at       = img_pos;
    diff     = b2 - b1;
    distance = at[15:0] - last_reloc_pos;
    if (!extract_halted) begin
      if (m == MODE_FINISH) begin
        // Terminator: two zero bytes, three in relative mode; then rewind.
        expect_byte(8'h00, 1'b0, ERR_NONE, at[15:0]);
        expect_byte(8'h00, ~rel_cfg, ERR_NONE, at[15:0]);
        if (rel_cfg) expect_byte(8'h00, 1'b1, ERR_NONE, at[15:0]);
        img_pos = '0;
        last_reloc_pos = '0;
      end else if (at[16]) begin
        // Pair past the last addressable offset, whatever its bytes.
        extract_halted = 1'b1;
        expect_byte(8'h00, 1'b1, ERR_LONG, at[15:0]);
      end else begin
        img_pos = at + 17'd1;
        if (diff != 8'h00) begin
          if (diff != step_cfg) begin
            extract_halted = 1'b1;
            expect_byte(8'h00, 1'b1, ERR_DIFF, at[15:0]);
          end else if (!rel_cfg) begin
            expect_byte(at[7:0], 1'b0, ERR_NONE, at[15:0]);
            expect_byte(at[15:8], 1'b1, ERR_NONE, at[15:0]);
          end else if (distance > 16'd255 && bytemode_cfg) begin
            extract_halted = 1'b1;
            expect_byte(8'h00, 1'b1, ERR_BIG, at[15:0]);
          end else if (distance > 16'd255) begin
            // Escape: zero byte, then the 16-bit distance low byte first.
            last_reloc_pos = at[15:0];
            expect_byte(8'h00, 1'b0, ERR_NONE, at[15:0]);
            expect_byte(distance[7:0], 1'b0, ERR_NONE, at[15:0]);
            expect_byte(distance[15:8], 1'b1, ERR_NONE, at[15:0]);
          end else begin
            last_reloc_pos = at[15:0];
            expect_byte(distance[7:0], 1'b1, ERR_NONE, at[15:0]);
          end
        end
      end
    end
  endfunction

  // Present one item and hold it until the extractor takes it. Push stays
  // high after the transfer so back-to-back items never drop it.
  task automatic send_item(input logic m, input logic [7:0] b1, input logic [7:0] b2);
    int gap;
    gap = send_idle ? rand_gap() : 0;
    @(negedge clk);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    push        <= 1'b1;
    mode        <= m;
    byte_first  <= b1;
    byte_second <= b2;
    do @(posedge clk); while (full !== 1'b0);
    extract_bytes(m, b1, b2);
  endtask

  // Pair with random content whose difference is d.
  task automatic send_pair(input logic [7:0] d);
    logic [7:0] b1;
    b1 = 8'($urandom);
    send_item(MODE_PAIR, b1, b1 + d);
  endtask

  // Unrelocated bytes: advance the position without any table output.
  task automatic send_run(input int n);
    repeat (n) send_pair(8'h00);
  endtask

  task automatic send_finish();
    send_item(MODE_FINISH, 8'($urandom), 8'($urandom));
  endtask

  // Drop push, drain every expected byte, then let in-flight pairs that
  // yield nothing clear the pipeline before registers change.
  task automatic settle();
    @(negedge clk);
    push <= 1'b0;
    while (table_bytes_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // Write one register over APB, read it back and update the shadow copy.
  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] val);
    logic [31:0] mask;
    logic [31:0] got;
    mask = (idx == REG_MSB_STEP) ? 32'h0000_00ff : 32'h0000_0001;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    // Read back: setup, then access.
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    got = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_MSB_STEP:      step_cfg = val[7:0];
      REG_RELATIVE_MODE: rel_cfg = val[0];
      REG_BYTE_MODE:     bytemode_cfg = val[0];
      default: ;
    endcase
    if ((got & mask) !== (val & mask)) begin
      $display("%0t: register %0d read back: expected %h, actual %h",
               $time, idx, val & mask, got & mask);
      mismatches++;
    end
  endtask

  // Absolute mode at reset settings: offsets zero and small, byte wrap in
  // the difference, extreme byte values, a terminator and an empty image.
  task automatic test_absolute();
    send_pair(8'h01);
    send_item(MODE_PAIR, 8'h00, 8'h00);
    send_item(MODE_PAIR, 8'hff, 8'hff);
    send_item(MODE_PAIR, 8'hff, 8'h00);
    send_item(MODE_PAIR, 8'h00, 8'h01);
    send_finish();
    send_finish();
  endtask

  // Relative mode: distance zero at offset 0, the largest step value, short
  // distances in byte mode, and the three-byte terminator.
  task automatic test_relative();
    settle();
    cfg_write(REG_MSB_STEP, 32'd255);
    cfg_write(REG_RELATIVE_MODE, 32'd1);
    send_pair(8'hff);
    send_item(MODE_PAIR, 8'h00, 8'hff);
    send_run(3);
    send_item(MODE_PAIR, 8'h80, 8'h7f);
    send_finish();
    settle();
    cfg_write(REG_MSB_STEP, 32'h80);
    cfg_write(REG_BYTE_MODE, 32'd1);
    send_item(MODE_PAIR, 8'h7f, 8'hff);
    send_run(2);
    send_pair(8'h80);
    send_finish();
  endtask

  // Small random images under four settings, covering every mode pair. In
  // relative byte mode close the image instead of relocating too far away.
  task automatic test_random();
    int r;
    int n;
    for (int phase = 0; phase < 4; phase++) begin
      settle();
      case (phase)
        0:       cfg_write(REG_MSB_STEP, 32'd1);
        1:       cfg_write(REG_MSB_STEP, 32'd255);
        default: cfg_write(REG_MSB_STEP, $urandom_range(1, 255));
      endcase
      cfg_write(REG_RELATIVE_MODE, phase % 2);
      cfg_write(REG_BYTE_MODE, (phase / 2) % 2);
      // Leave one phase per side free of idling.
      send_idle = (phase != 2);
      pop_idle  = (phase != 3);
      for (int ev = 0; ev < 3; ev++) begin
        r = $urandom_range(0, 99);
        if (r < 6) begin
          send_finish();
        end else begin
          n = $urandom_range(0, 3);
          send_run(n);
          if (rel_cfg && bytemode_cfg && 16'(img_pos[15:0] - last_reloc_pos) > 16'd255)
            send_finish();
          else
            send_pair(step_cfg);
        end
      end
    end
    send_idle = 1'b1;
    pop_idle  = 1'b1;
  endtask

  // A relocation 256 bytes after the previous one: the escape form with
  // byte mode off, or the distance error that halts the block with it on.
  task automatic test_long_distance();
    settle();
    cfg_write(REG_BYTE_MODE, 32'd0);
    cfg_write(REG_RELATIVE_MODE, 32'd1);
    cfg_write(REG_MSB_STEP, $urandom_range(1, 255));
    send_pair(step_cfg);
    send_run(255);
    settle();
    cfg_write(REG_BYTE_MODE, $urandom_range(0, 1));
    send_pair(step_cfg);
  endtask

  // One error per run, since only reset clears the halt: unless the block
  // already halted, pick the kind at random, then check that later items,
  // finish included, yield nothing.
  task automatic test_halt();
    logic [7:0] d;
    if (!extract_halted) begin
      if ($urandom_range(0, 1) == 0) begin
        // Nonzero difference other than the step.
        do d = 8'($urandom); while (d == 8'h00 || d == step_cfg);
        send_pair(d);
      end else begin
        // Step of zero: every nonzero difference is invalid.
        settle();
        cfg_write(REG_MSB_STEP, 32'd0);
        send_pair(8'($urandom_range(1, 255)));
      end
    end
    repeat (6) send_item(1'($urandom_range(0, 1)), 8'($urandom), 8'($urandom));
  endtask

  // Pop side: accept at random, with stalls drawn after each pop.
  initial begin : pop_driver
    int hold;
    hold = 0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        pop <= 1'b0;
        hold--;
      end else begin
        pop <= 1'b1;
        if (pop_idle) hold = rand_gap();
      end
    end
  end

  // Compare each popped byte, field by field, with the oldest prediction.
  always @(posedge clk) begin : check_results
    table_byte_t want;
    if (!rst && pop && !empty) begin
      if (table_bytes_q.size() == 0) begin
        $display("%0t: unexpected byte: expected none, actual %h pos %h err %0d",
                 $time, out_byte, position, error_code);
        mismatches++;
      end else begin
        want = table_bytes_q.pop_front();
        if (out_byte !== want.value) begin
          $display("%0t: out_byte: expected %h, actual %h", $time, want.value, out_byte);
          mismatches++;
        end
        if (last_of_run !== want.last) begin
          $display("%0t: last_of_run: expected %b, actual %b", $time, want.last,
                   last_of_run);
          mismatches++;
        end
        if (error_code !== want.err) begin
          $display("%0t: error_code: expected %0d, actual %0d", $time, want.err,
                   error_code);
          mismatches++;
        end
        if (position !== want.pos) begin
          $display("%0t: position: expected %h, actual %h", $time, want.pos, position);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: end the run if neither side transfers for too long.
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("relocation_table_extractor: mismatch");
      $finish;
    end
  end

  initial begin
    // Hold reset, then release it on a falling edge.
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_absolute();
    test_relative();
    test_random();
    test_long_distance();
    test_halt();

    // Drain, then wait for anything stray to show up.
    settle();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && table_bytes_q.size() == 0)
      $display("relocation_table_extractor: match");
    else
      $display("relocation_table_extractor: mismatch");
    $finish;
  end

endmodule

// File: filelist.f
design/rte_pkg.sv
design/rte_front.sv
design/rte_cmd_fifo.sv
design/rte_back.sv
design/relocation_table_extractor.sv
design/rte_checker.sv
bench/tb.sv
